/* hdl/atcg_pkg.sv */
// shared types, codes and lookup functions of the terminal cell grid engine
package atcg_pkg;

	// default geometry
	localparam int ROWS_DEF       = 25;
	localparam int COLS_DEF       = 80;
	localparam int MAX_PARAMS_DEF = 8;

	// field widths of the stream payload
	localparam int ROW_FW  = 5;
	localparam int COL_FW  = 7;
	localparam int BYTE_W  = 8;
	localparam int IN_DW   = 24;
	localparam int OUT_DW  = 32;

	// control and special bytes
	localparam logic [7:0] ESC_CODE   = 8'h1B;
	localparam logic [7:0] SO_CODE    = 8'h0E;
	localparam logic [7:0] SI_CODE    = 8'h0F;
	localparam logic [7:0] BS_CODE    = 8'h08;
	localparam logic [7:0] HT_CODE    = 8'h09;
	localparam logic [7:0] LF_CODE    = 8'h0A;
	localparam logic [7:0] CR_CODE    = 8'h0D;
	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] INV_BIT    = 8'h80;

	// parser states
	localparam logic [1:0] PS_GROUND = 2'd0;
	localparam logic [1:0] PS_ESC    = 2'd1;
	localparam logic [1:0] PS_CSI    = 2'd2;
	localparam logic [1:0] PS_DESIG  = 2'd3;

	// charset bit positions
	localparam int CS_G0_GFX    = 0;
	localparam int CS_G1_GFX    = 1;
	localparam int CS_G1_ACTIVE = 2;
	localparam int CS_TARGET_G1 = 3;

	// one classified input transaction
	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
		logic       rd_ok;
		logic       is_digit;
		logic       is_final;
	} item_t;

	// control from the back part to the front part
	typedef struct packed {
		logic pop;
		logic clearing;
	} ctl_t;

	// ansi colour index to attribute colour
	function automatic logic [2:0] colour_map(input logic [2:0] i);
		logic [2:0] r;
		case (i)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	// line drawing glyphs of the special graphics set
	function automatic logic [7:0] glyph_map(input logic [7:0] b, input logic gfx);
		logic [7:0] r;
		r = b;
		if (gfx) begin
			case (b)
				"q": r = 8'h80;
				"x": r = 8'h81;
				"l": r = 8'h82;
				"k": r = 8'h83;
				"m": r = 8'h84;
				"j": r = 8'h85;
				"t": r = 8'h86;
				"u": r = 8'h87;
				"v": r = 8'h88;
				"w": r = 8'h89;
				"n": r = 8'h8A;
				default: r = b;
			endcase
		end
		return r;
	endfunction

	// one graphic rendition parameter applied to an attribute
	function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [15:0] p);
		logic [7:0]  r;
		logic [15:0] o30;
		logic [15:0] o40;
		logic [15:0] o90;
		r   = a;
		o30 = p - 16'd30;
		o40 = p - 16'd40;
		o90 = p - 16'd90;
		if (p == 16'd0) r = RESET_ATTR;
		else if (p == 16'd1) r = a | 8'h08;
		else if (p == 16'd7) r = a | INV_BIT;
		else if (p == 16'd27) r = a & ~INV_BIT;
		else if (p >= 16'd30 && p <= 16'd37) r = (a & 8'hF8) | {5'd0, colour_map(o30[2:0])};
		else if (p >= 16'd40 && p <= 16'd47)
			r = (a & 8'h8F) | {1'b0, colour_map(o40[2:0]), 4'd0};
		else if (p >= 16'd90 && p <= 16'd97)
			r = (a & 8'hF0) | {5'd0, colour_map(o90[2:0])} | 8'h08;
		return r;
	endfunction

endpackage

/* hdl/ansi_terminal_cell_grid_core.sv */
// top level of the terminal cell grid engine
// a read or plain control byte goes from the queue head to the finish state, a
// printed byte via a print state, a sgr final via the sgr state once per parameter
// erase clears one cell per cycle; scroll and insert copy each moved row by a read
// then a write per column (one grid ram port pair shared by read and write)
// a 2-entry input queue keeps accepting while the executor works or the result waits
// after reset the grid is cleared to blanks with s_tready held low
module ansi_terminal_cell_grid_core #(
	parameter int ROWS       = atcg_pkg::ROWS_DEF,
	parameter int COLS       = atcg_pkg::COLS_DEF,
	parameter int MAX_PARAMS = atcg_pkg::MAX_PARAMS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [atcg_pkg::IN_DW-1:0]   s_tdata,  // data_byte, read_row, read_col
	input  logic                         s_tuser,  // command
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [atcg_pkg::OUT_DW-1:0]  m_tdata   // cell_char, cell_attr, cursor_row, cursor_col
);
	import atcg_pkg::*;

	localparam int AW = $clog2(ROWS * COLS);

	ctl_t          ctl;
	logic          q_valid;
	item_t         q_item;
	logic [AW-1:0] q_addr;

	// accept and classify
	atcg_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.ctl      (ctl),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_addr   (q_addr)
	);

	// execute against the grid
	atcg_exec #(.ROWS(ROWS), .COLS(COLS), .MAX_PARAMS(MAX_PARAMS)) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_addr   (q_addr),
		.ctl      (ctl),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hdl/atcg_ram.sv */
// generic single write port ram with registered read
module atcg_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/atcg_front.sv */
// front part: accepts, classifies and queues input transactions
module atcg_front #(
	parameter int ROWS = atcg_pkg::ROWS_DEF,
	parameter int COLS = atcg_pkg::COLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [atcg_pkg::IN_DW-1:0]      s_tdata,
	input  logic                            s_tuser,
	input  atcg_pkg::ctl_t                  ctl,
	output logic                            q_valid,
	output atcg_pkg::item_t                 q_item,
	output logic [$clog2(ROWS*COLS)-1:0]    q_addr
);
	import atcg_pkg::*;

	localparam int AW = $clog2(ROWS*COLS);

	item_t          in_item;
	logic [AW-1:0]  in_addr;
	logic [7:0]     in_byte;
	logic [4:0]     in_row;
	logic [6:0]     in_col;
	logic           push;
	item_t          item_q [2];
	logic [AW-1:0]  addr_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	// classify the incoming byte and precompute the cell address
	always_comb begin
		in_byte          = s_tdata[7:0];
		in_row           = s_tdata[12:8];
		in_col           = s_tdata[19:13];
		in_item.cmd      = s_tuser;
		in_item.data     = in_byte;
		in_item.rd_ok    = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLS));
		in_item.is_digit = in_byte inside {[8'h30:8'h39]};
		in_item.is_final = in_byte inside {[8'h40:8'h7E]};
		in_addr          = AW'(32'(in_row) * 32'(COLS) + 32'(in_col));
	end

	assign s_tready = (cnt_q != 2'd2) && !ctl.clearing;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = item_q[rp_q];
	assign q_addr   = addr_q[rp_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (ctl.pop) rp_q <= ~rp_q;
			case ({push, ctl.pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wp_q] <= in_item;
			addr_q[wp_q] <= in_addr;
		end
	end

endmodule

/* hdl/atcg_exec.sv */
// back part: parser state, cursor, grid sequencer and result register
module atcg_exec #(
	parameter int ROWS       = atcg_pkg::ROWS_DEF,
	parameter int COLS       = atcg_pkg::COLS_DEF,
	parameter int MAX_PARAMS = atcg_pkg::MAX_PARAMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  atcg_pkg::item_t                 q_item,
	input  logic [$clog2(ROWS*COLS)-1:0]    q_addr,
	output atcg_pkg::ctl_t                  ctl,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [atcg_pkg::OUT_DW-1:0]     m_tdata
);
	import atcg_pkg::*;

	localparam int NCELL = ROWS * COLS;
	localparam int AW    = $clog2(NCELL);
	localparam int NW    = $clog2(NCELL + 1);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS + 1);
	localparam int PW    = $clog2(MAX_PARAMS);
	localparam int PCW   = $clog2(MAX_PARAMS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FIN    = 4'd1;
	localparam logic [3:0] S_PRINT  = 4'd2;
	localparam logic [3:0] S_FILL   = 4'd3;
	localparam logic [3:0] S_ROW    = 4'd4;
	localparam logic [3:0] S_ROWNXT = 4'd5;
	localparam logic [3:0] S_CPRD   = 4'd6;
	localparam logic [3:0] S_CPWR   = 4'd7;
	localparam logic [3:0] S_SGR    = 4'd8;

	localparam logic [16:0] ROWMAX = 17'(ROWS - 1);
	localparam logic [16:0] COLMAX = 17'(COLS - 1);

	// control state
	logic [3:0]    st_q, st_d;
	logic          clr_q, clr_d;
	logic [RW-1:0] cur_row_q, cur_row_d;
	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [RW-1:0] sav_row_q, sav_row_d;
	logic [CW-1:0] sav_col_q, sav_col_d;
	logic [7:0]    attr_q, attr_d;
	logic [RW-1:0] top_q, top_d;
	logic [RW-1:0] bot_q, bot_d;
	logic [1:0]    ps_q, ps_d;
	logic [15:0]   prm_q [MAX_PARAMS];
	logic [15:0]   prm_d [MAX_PARAMS];
	logic [PCW-1:0] pcnt_q, pcnt_d;
	logic          fdig_q, fdig_d;
	logic          fpriv_q, fpriv_d;
	logic [3:0]    cs_q, cs_d;
	logic [NW-1:0] fa_q, fa_d;
	logic [NW-1:0] fe_q, fe_d;
	logic [3:0]    fret_q, fret_d;
	logic          out_valid_q, out_valid_d;

	// sequencer payload
	logic [RW-1:0] ro_r_q, ro_r_d;
	logic [RW-1:0] ro_src_q, ro_src_d;
	logic [RW-1:0] ro_top_q, ro_top_d;
	logic [RW-1:0] ro_bot_q, ro_bot_d;
	logic [15:0]   ro_n_q, ro_n_d;
	logic          ro_down_q, ro_down_d;
	logic          ro_prt_q, ro_prt_d;
	logic [CW-1:0] col_q, col_d;
	logic [7:0]    glyph_q, glyph_d;
	logic          rd_q, rd_d;
	logic [PW-1:0] sgr_i_q, sgr_i_d;
	logic [7:0]    o_char_q, o_attr_q;
	logic [ROW_FW-1:0] o_row_q;
	logic [COL_FW-1:0] o_col_q;

	// working signals
	logic          pop;
	logic [RW-1:0] mrow;
	logic [CW-1:0] mcol;
	logic [NW-1:0] mul_addr;
	logic [AW-1:0] raddr;
	logic          we;
	logic [7:0]    wchar, wattr;
	logic [7:0]    rchar, rattr;
	logic [PW-1:0] pidx;
	logic [PW-1:0] kidx;
	logic [15:0]   prd;
	logic [15:0]   p0, p1, n;
	logic [16:0]   row17, col17, n17, t17, b17;
	logic [19:0]   v20;
	logic [PCW-1:0] c1;
	logic [7:0]    b;
	logic          ld_scroll, lu_scroll;
	logic [RW-1:0] ld_row, lu_row;
	logic [CW-1:0] col_inc;
	logic          gfx;
	logic          start_ro, start_fill;
	logic          ro_down_v, ro_prt_v;
	logic [RW-1:0] ro_top_v;
	logic [15:0]   ro_n_v;
	logic [NW-1:0] fs, fe;
	logic [3:0]    fret;
	logic [16:0]   rsum, rdiff;
	logic          rcopy, rlast;

	function automatic logic [CW-1:0] clamp_col(input logic [16:0] x);
		return (x > COLMAX) ? CW'(COLS - 1) : CW'(x);
	endfunction

	function automatic logic [RW-1:0] clamp_row(input logic [16:0] x);
		return (x > ROWMAX) ? RW'(ROWS - 1) : RW'(x);
	endfunction

	// shared cell address: row times width plus column
	assign mul_addr = NW'(NW'(mrow) * NW'(COLS) + NW'(mcol));

	// sequence parameter helpers
	assign kidx  = (pcnt_q == '0) ? '0 : PW'(pcnt_q - PCW'(1));
	assign prd   = prm_q[pidx];
	assign p0    = (pcnt_q != '0) ? prm_q[0] : 16'd0;
	assign p1    = (pcnt_q > PCW'(1)) ? prm_q[1] : 16'd0;
	assign n     = (p0 == 16'd0) ? 16'd1 : p0;
	assign row17 = 17'(cur_row_q);
	assign col17 = 17'(cur_col_q);
	assign n17   = 17'(n);
	assign b     = q_item.data;
	assign v20   = (20'(prd) << 3) + (20'(prd) << 1) + 20'(b[3:0]);
	assign c1    = (pcnt_q == '0) ? PCW'(1) : pcnt_q;
	assign gfx   = cs_q[CS_G1_ACTIVE] ? cs_q[CS_G1_GFX] : cs_q[CS_G0_GFX];

	// line feed and reverse index outcomes
	assign ld_scroll = (cur_row_q == bot_q);
	assign ld_row    = (cur_row_q < RW'(ROWS - 1)) ? cur_row_q + RW'(1) : cur_row_q;
	assign lu_scroll = (cur_row_q == top_q);
	assign lu_row    = (cur_row_q != '0) ? cur_row_q - RW'(1) : cur_row_q;
	assign col_inc   = (cur_col_q == CW'(COLS)) ? CW'(COLS) : cur_col_q + CW'(1);

	// row loop decisions
	assign rsum  = 17'(ro_r_q) + 17'(ro_n_q);
	assign rdiff = 17'(ro_r_q - ro_top_q);
	assign rcopy = ro_down_q ? (rdiff >= 17'(ro_n_q)) : (rsum <= 17'(ro_bot_q));
	assign rlast = ro_down_q ? (ro_r_q == ro_top_q) : (ro_r_q == ro_bot_q);

	// next state of the sequencer and the terminal
	always_comb begin
		st_d        = st_q;
		clr_d       = clr_q;
		cur_row_d   = cur_row_q;
		cur_col_d   = cur_col_q;
		sav_row_d   = sav_row_q;
		sav_col_d   = sav_col_q;
		attr_d      = attr_q;
		top_d       = top_q;
		bot_d       = bot_q;
		ps_d        = ps_q;
		prm_d       = prm_q;
		pcnt_d      = pcnt_q;
		fdig_d      = fdig_q;
		fpriv_d     = fpriv_q;
		cs_d        = cs_q;
		fa_d        = fa_q;
		fe_d        = fe_q;
		fret_d      = fret_q;
		out_valid_d = out_valid_q;
		ro_r_d      = ro_r_q;
		ro_src_d    = ro_src_q;
		ro_top_d    = ro_top_q;
		ro_bot_d    = ro_bot_q;
		ro_n_d      = ro_n_q;
		ro_down_d   = ro_down_q;
		ro_prt_d    = ro_prt_q;
		col_d       = col_q;
		glyph_d     = glyph_q;
		rd_d        = rd_q;
		sgr_i_d     = sgr_i_q;
		pop         = 1'b0;
		mrow        = cur_row_q;
		mcol        = '0;
		raddr       = AW'(mul_addr);
		we          = 1'b0;
		wchar       = SPACE_CODE;
		wattr       = attr_q;
		pidx        = kidx;
		start_ro    = 1'b0;
		ro_down_v   = 1'b0;
		ro_top_v    = top_q;
		ro_n_v      = 16'd1;
		ro_prt_v    = 1'b0;
		start_fill  = 1'b0;
		fs          = '0;
		fe          = NW'(NCELL);
		fret        = S_FIN;
		t17         = '0;
		b17         = '0;

		if (out_valid_q && m_tready) out_valid_d = 1'b0;

		case (st_q)
			S_IDLE: begin
				if (q_valid && (!out_valid_q || m_tready)) begin
					pop   = 1'b1;
					st_d  = S_FIN;
					rd_d  = q_item.cmd & q_item.rd_ok;
					if (q_item.cmd) begin
						raddr = q_addr;
					end else begin
						case (ps_q)
							PS_GROUND: begin
								if (b == ESC_CODE) ps_d = PS_ESC;
								else if (b == SO_CODE) cs_d[CS_G1_ACTIVE] = 1'b1;
								else if (b == SI_CODE) cs_d[CS_G1_ACTIVE] = 1'b0;
								else if (b == BS_CODE) begin
									if (cur_col_q != '0) cur_col_d = cur_col_q - CW'(1);
								end else if (b == HT_CODE) begin
									cur_col_d = clamp_col((col17 + 17'd8) & ~17'd7);
								end else if (b == LF_CODE) begin
									cur_col_d = '0;
									if (ld_scroll) start_ro = 1'b1;
									else cur_row_d = ld_row;
								end else if (b == CR_CODE) cur_col_d = '0;
								else if (b >= SPACE_CODE) begin
									glyph_d = glyph_map(b, gfx);
									st_d    = S_PRINT;
									if (cur_col_q >= CW'(COLS)) begin
										cur_col_d = '0;
										if (ld_scroll) begin
											start_ro = 1'b1;
											ro_prt_v = 1'b1;
										end else cur_row_d = ld_row;
									end
								end
							end
							PS_ESC: begin
								ps_d = PS_GROUND;
								if (b == "[") begin
									ps_d     = PS_CSI;
									pcnt_d   = '0;
									prm_d[0] = 16'd0;
									fdig_d   = 1'b0;
									fpriv_d  = 1'b0;
								end else if (b == "(" || b == ")") begin
									cs_d[CS_TARGET_G1] = (b == ")");
									ps_d = PS_DESIG;
								end else if (b == "D" || b == "E") begin
									if (b == "E") cur_col_d = '0;
									if (ld_scroll) start_ro = 1'b1;
									else cur_row_d = ld_row;
								end else if (b == "M") begin
									if (lu_scroll) begin
										start_ro  = 1'b1;
										ro_down_v = 1'b1;
									end else cur_row_d = lu_row;
								end else if (b == "7") begin
									sav_row_d = cur_row_q;
									sav_col_d = cur_col_q;
								end else if (b == "8") begin
									cur_row_d = sav_row_q;
									cur_col_d = clamp_col(17'(sav_col_q));
								end
							end
							PS_CSI: begin
								if (q_item.is_digit) begin
									if (pcnt_q == '0) pcnt_d = PCW'(1);
									prm_d[kidx] = (v20 > 20'd65535) ? 16'hFFFF : v20[15:0];
									fdig_d = 1'b1;
								end else if (b == ";") begin
									if (c1 < PCW'(MAX_PARAMS)) begin
										prm_d[PW'(c1)] = 16'd0;
										pcnt_d = c1 + PCW'(1);
									end else pcnt_d = c1;
									fdig_d = 1'b0;
								end else if (b == "?" && pcnt_q == '0 && !fdig_q) begin
									fpriv_d = 1'b1;
								end else if (b == ">" || b == "=") begin
									ps_d = PS_CSI;
								end else if (q_item.is_final) begin
									ps_d    = PS_GROUND;
									fpriv_d = 1'b0;
									if (!fpriv_q) begin
										case (b)
											"H", "f": begin
												t17 = (p0 == 16'd0) ? 17'd0 : 17'(p0) - 17'd1;
												b17 = (p1 == 16'd0) ? 17'd0 : 17'(p1) - 17'd1;
												cur_row_d = clamp_row(t17);
												cur_col_d = clamp_col(b17);
											end
											"A": begin
												cur_row_d = (n17 >= row17) ? '0 : RW'(row17 - n17);
												cur_col_d = clamp_col(col17);
											end
											"B": begin
												cur_row_d = clamp_row(row17 + n17);
												cur_col_d = clamp_col(col17);
											end
											"C": cur_col_d = clamp_col(col17 + n17);
											"D": begin
												t17 = (n17 >= col17) ? 17'd0 : col17 - n17;
												cur_col_d = clamp_col(t17);
											end
											"J": begin
												cs_d[CS_G1_ACTIVE] = 1'b0;
												if (p0 == 16'd2 || p0 == 16'd3) begin
													start_fill = 1'b1;
												end else if (p0 == 16'd0) begin
													start_fill = 1'b1;
													fs = mul_addr + NW'(cur_col_q);
												end else if (p0 == 16'd1) begin
													start_fill = 1'b1;
													fe = mul_addr + NW'(col_inc);
												end
											end
											"K": begin
												start_fill = 1'b1;
												fs = mul_addr;
												fe = mul_addr + NW'(COLS);
												if (p0 == 16'd0) fs = mul_addr + NW'(cur_col_q);
												else if (p0 == 16'd1) fe = mul_addr + NW'(col_inc);
											end
											"m": begin
												if (pcnt_q == '0) attr_d = RESET_ATTR;
												else begin
													sgr_i_d = '0;
													st_d    = S_SGR;
												end
											end
											"r": begin
												t17 = (p0 == 16'd0) ? 17'd0 : 17'(p0) - 17'd1;
												b17 = (pcnt_q > PCW'(1)) ? 17'(p1) - 17'd1 : ROWMAX;
												if (b17 > ROWMAX) b17 = ROWMAX;
												if ((pcnt_q > PCW'(1) && p1 == 16'd0) || t17 > b17) begin
													top_d = '0;
													bot_d = RW'(ROWS - 1);
												end else begin
													top_d = RW'(t17);
													bot_d = RW'(b17);
												end
												cur_row_d = '0;
												cur_col_d = '0;
											end
											"s": begin
												sav_row_d = cur_row_q;
												sav_col_d = cur_col_q;
											end
											"u": begin
												cur_row_d = sav_row_q;
												cur_col_d = clamp_col(17'(sav_col_q));
											end
											"M", "S": begin
												start_ro = 1'b1;
												ro_n_v   = n;
											end
											"T": begin
												start_ro  = 1'b1;
												ro_down_v = 1'b1;
												ro_n_v    = n;
											end
											"L": begin
												if (cur_row_q <= bot_q) begin
													start_ro  = 1'b1;
													ro_down_v = 1'b1;
													ro_top_v  = cur_row_q;
													ro_n_v    = n;
												end else begin
													start_fill = 1'b1;
													fs = mul_addr;
													fe = mul_addr + NW'(COLS);
												end
											end
											default: ps_d = PS_GROUND;
										endcase
									end
								end else begin
									ps_d    = PS_GROUND;
									fpriv_d = 1'b0;
								end
							end
							default: begin
								if (cs_q[CS_TARGET_G1]) begin
									cs_d[CS_G1_GFX]    = (b == "0");
									cs_d[CS_G1_ACTIVE] = (b == "0");
								end else cs_d[CS_G0_GFX] = (b == "0");
								ps_d = PS_GROUND;
							end
						endcase
					end
				end
			end
			S_PRINT: begin
				mrow      = cur_row_q;
				mcol      = cur_col_q;
				we        = 1'b1;
				wchar     = glyph_q;
				cur_col_d = cur_col_q + CW'(1);
				st_d      = S_FIN;
			end
			S_FILL: begin
				if (fa_q == fe_q) begin
					st_d  = fret_q;
					clr_d = 1'b0;
				end else begin
					we   = 1'b1;
					fa_d = fa_q + NW'(1);
				end
			end
			S_ROW: begin
				mrow = ro_r_q;
				if (rcopy) begin
					ro_src_d = ro_down_q ? ro_r_q - RW'(ro_n_q) : RW'(rsum);
					col_d    = '0;
					st_d     = S_CPRD;
				end else begin
					start_fill = 1'b1;
					fs   = mul_addr;
					fe   = mul_addr + NW'(COLS);
					fret = S_ROWNXT;
				end
			end
			S_ROWNXT: begin
				if (rlast) st_d = ro_prt_q ? S_PRINT : S_FIN;
				else begin
					ro_r_d = ro_down_q ? ro_r_q - RW'(1) : ro_r_q + RW'(1);
					st_d   = S_ROW;
				end
			end
			S_CPRD: begin
				mrow = ro_src_q;
				mcol = col_q;
				st_d = S_CPWR;
			end
			S_CPWR: begin
				mrow  = ro_r_q;
				mcol  = col_q;
				we    = 1'b1;
				wchar = rchar;
				wattr = rattr;
				if (col_q == CW'(COLS - 1)) st_d = S_ROWNXT;
				else begin
					col_d = col_q + CW'(1);
					st_d  = S_CPRD;
				end
			end
			S_SGR: begin
				pidx   = sgr_i_q;
				attr_d = sgr_apply(attr_q, prd);
				if (PCW'(sgr_i_q) + PCW'(1) == pcnt_q) st_d = S_FIN;
				else sgr_i_d = sgr_i_q + PW'(1);
			end
			S_FIN: begin
				out_valid_d = 1'b1;
				st_d        = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase

		// launch a row shift over a span of rows
		if (start_ro) begin
			ro_down_d = ro_down_v;
			ro_top_d  = ro_top_v;
			ro_bot_d  = bot_q;
			ro_n_d    = ro_n_v;
			ro_prt_d  = ro_prt_v;
			ro_r_d    = ro_down_v ? bot_q : ro_top_v;
			st_d      = S_ROW;
		end
		// launch a linear blank fill
		if (start_fill) begin
			fa_d   = fs;
			fe_d   = fe;
			fret_d = fret;
			st_d   = S_FILL;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_FILL;
			clr_q       <= 1'b1;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			sav_row_q   <= '0;
			sav_col_q   <= '0;
			attr_q      <= RESET_ATTR;
			top_q       <= '0;
			bot_q       <= RW'(ROWS - 1);
			ps_q        <= PS_GROUND;
			prm_q       <= '{default: 16'd0};
			pcnt_q      <= '0;
			fdig_q      <= 1'b0;
			fpriv_q     <= 1'b0;
			cs_q        <= 4'd0;
			fa_q        <= '0;
			fe_q        <= NW'(NCELL);
			fret_q      <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			clr_q       <= clr_d;
			cur_row_q   <= cur_row_d;
			cur_col_q   <= cur_col_d;
			sav_row_q   <= sav_row_d;
			sav_col_q   <= sav_col_d;
			attr_q      <= attr_d;
			top_q       <= top_d;
			bot_q       <= bot_d;
			ps_q        <= ps_d;
			prm_q       <= prm_d;
			pcnt_q      <= pcnt_d;
			fdig_q      <= fdig_d;
			fpriv_q     <= fpriv_d;
			cs_q        <= cs_d;
			fa_q        <= fa_d;
			fe_q        <= fe_d;
			fret_q      <= fret_d;
			out_valid_q <= out_valid_d;
		end
	end

	// sequencer payload and result registers
	always_ff @(posedge clk) begin
		ro_r_q    <= ro_r_d;
		ro_src_q  <= ro_src_d;
		ro_top_q  <= ro_top_d;
		ro_bot_q  <= ro_bot_d;
		ro_n_q    <= ro_n_d;
		ro_down_q <= ro_down_d;
		ro_prt_q  <= ro_prt_d;
		col_q     <= col_d;
		glyph_q   <= glyph_d;
		rd_q      <= rd_d;
		sgr_i_q   <= sgr_i_d;
		if (st_q == S_FIN) begin
			o_char_q <= rd_q ? rchar : 8'd0;
			o_attr_q <= rd_q ? rattr : 8'd0;
			o_row_q  <= ROW_FW'(cur_row_q);
			o_col_q  <= COL_FW'(cur_col_q);
		end
	end

	// character and attribute planes
	atcg_ram #(.W(8), .DEPTH(NCELL)) u_char_ram (
		.clk   (clk),
		.we    (we),
		.waddr (st_q == S_FILL ? AW'(fa_q) : AW'(mul_addr)),
		.wdata (wchar),
		.raddr (raddr),
		.rdata (rchar)
	);

	atcg_ram #(.W(8), .DEPTH(NCELL)) u_attr_ram (
		.clk   (clk),
		.we    (we),
		.waddr (st_q == S_FILL ? AW'(fa_q) : AW'(mul_addr)),
		.wdata (wattr),
		.raddr (raddr),
		.rdata (rattr)
	);

	assign ctl.pop      = pop;
	assign ctl.clearing = clr_q;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {4'd0, o_col_q, o_row_q, o_attr_q, o_char_q};

	// cursor and region stay on the grid, the cursor column at most at the pending wrap position
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= CW'(COLS)) else $error("cursor column beyond pending wrap");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q <= RW'(ROWS - 1)) else $error("cursor row off grid");
	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= bot_q && bot_q <= RW'(ROWS - 1)) else $error("bad scroll region");
	a_param_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PCW'(MAX_PARAMS)) else $error("parameter count overflow");
	// a result appears only at the end of a transaction
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == S_FIN)) else $error("stray result");
	// nothing is popped while the grid is being cleared
	a_no_pop_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !pop) else $error("pop during clearing pass");

endmodule

/* test/ansi_terminal_cell_grid_core_test.sv */
// testbench of the terminal cell grid engine: directed and random byte streams checked cell by cell
`timescale 1ns / 1ps

module ansi_terminal_cell_grid_core_test;
	import atcg_pkg::*;

	localparam int NROWS = ROWS_DEF;
	localparam int NCOLS = COLS_DEF;
	localparam int NPARAMS = MAX_PARAMS_DEF;
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam int PARAM_MAX = 65535;

	typedef struct {
		logic [7:0] ch;
		logic [7:0] at;
		logic [4:0] row;
		logic [6:0] col;
	} cell_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_DW-1:0]   m_tdata;

	cell_result_t pending_cells[$];
	int           error_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	// shadow terminal state
	logic [7:0] sh_char[NROWS*NCOLS];
	logic [7:0] sh_attr[NROWS*NCOLS];
	int         crow, ccol, srow, scol, rtop, rbot;
	logic [7:0] cattr;
	logic [1:0] pstate;
	int         prm[NPARAMS];
	int         pcnt;
	logic       fdigit, fpriv;
	logic [3:0] cset;

	ansi_terminal_cell_grid_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow grid helpers
	function automatic void blank_span(int row, int c0, int c1);
		if (row >= NROWS) return;
		for (int c = c0; c < c1 && c < NCOLS; c++) begin
			sh_char[row*NCOLS+c] = SPACE_CODE;
			sh_attr[row*NCOLS+c] = cattr;
		end
	endfunction

	function automatic void copy_row(int dst, int src);
		for (int c = 0; c < NCOLS; c++) begin
			sh_char[dst*NCOLS+c] = sh_char[src*NCOLS+c];
			sh_attr[dst*NCOLS+c] = sh_attr[src*NCOLS+c];
		end
	endfunction

	function automatic void scroll_rows_up(int top, int bot, int n);
		if (n > bot - top) begin
			for (int r = top; r <= bot; r++) blank_span(r, 0, NCOLS);
			return;
		end
		for (int r = top; r + n <= bot; r++) copy_row(r, r + n);
		for (int r = bot + 1 - n; r <= bot; r++) blank_span(r, 0, NCOLS);
	endfunction

	function automatic void scroll_rows_down(int top, int bot, int n);
		if (n > bot - top) begin
			for (int r = top; r <= bot; r++) blank_span(r, 0, NCOLS);
			return;
		end
		for (int r = bot; r >= top + n; r--) copy_row(r, r - n);
		for (int r = top; r < top + n; r++) blank_span(r, 0, NCOLS);
	endfunction

	function automatic void step_down();
		if (crow == rbot) scroll_rows_up(rtop, rbot, 1);
		else if (crow < NROWS - 1) crow++;
	endfunction

	function automatic void step_up();
		if (crow == rtop) scroll_rows_down(rtop, rbot, 1);
		else if (crow > 0) crow--;
	endfunction

	function automatic void move_to(int r, int c);
		crow = (r < 0) ? 0 : (r > NROWS - 1) ? NROWS - 1 : r;
		ccol = (c < 0) ? 0 : (c > NCOLS - 1) ? NCOLS - 1 : c;
	endfunction

	function automatic logic [7:0] line_glyph(logic [7:0] b);
		logic gfx;
		logic [7:0] r;
		gfx = cset[CS_G1_ACTIVE] ? cset[CS_G1_GFX] : cset[CS_G0_GFX];
		r = b;
		if (gfx) begin
			case (b)
				"q": r = 8'h80;
				"x": r = 8'h81;
				"l": r = 8'h82;
				"k": r = 8'h83;
				"m": r = 8'h84;
				"j": r = 8'h85;
				"t": r = 8'h86;
				"u": r = 8'h87;
				"v": r = 8'h88;
				"w": r = 8'h89;
				"n": r = 8'h8A;
				default: r = b;
			endcase
		end
		return r;
	endfunction

	function automatic logic [2:0] ansi_colour(int i);
		logic [2:0] lut[8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
		return lut[i];
	endfunction

	function automatic void apply_rendition();
		logic [7:0] a;
		int p;
		a = cattr;
		if (pcnt == 0) begin
			cattr = RESET_ATTR;
			return;
		end
		for (int i = 0; i < pcnt && i < NPARAMS; i++) begin
			p = prm[i];
			if (p == 0) a = RESET_ATTR;
			else if (p == 1) a = a | 8'h08;
			else if (p == 7) a = a | INV_BIT;
			else if (p == 27) a = a & ~INV_BIT;
			else if (p >= 30 && p <= 37) a = (a & 8'hF8) | {5'd0, ansi_colour(p - 30)};
			else if (p >= 40 && p <= 47) a = (a & 8'h8F) | {1'b0, ansi_colour(p - 40), 4'd0};
			else if (p >= 90 && p <= 97) a = (a & 8'hF0) | {5'd0, ansi_colour(p - 90)} | 8'h08;
		end
		cattr = a;
	endfunction

	function automatic void run_final(logic [7:0] fin);
		int p0, p1, n, t, b;
		p0 = pcnt > 0 ? prm[0] : 0;
		p1 = pcnt > 1 ? prm[1] : 0;
		n = p0 ? p0 : 1;
		if (fpriv) return;
		case (fin)
			"H", "f": move_to((pcnt > 0 ? p0 : 1) - 1, (pcnt > 1 ? p1 : 1) - 1);
			"A": move_to(crow - n, ccol);
			"B": move_to(crow + n, ccol);
			"C": move_to(crow, ccol + n);
			"D": move_to(crow, ccol - n);
			"J": begin
				cset[CS_G1_ACTIVE] = 1'b0;
				if (p0 == 2 || p0 == 3) begin
					for (int r = 0; r < NROWS; r++) blank_span(r, 0, NCOLS);
				end else if (p0 == 0) begin
					blank_span(crow, ccol, NCOLS);
					for (int r = crow + 1; r < NROWS; r++) blank_span(r, 0, NCOLS);
				end else if (p0 == 1) begin
					for (int r = 0; r < crow; r++) blank_span(r, 0, NCOLS);
					blank_span(crow, 0, ccol + 1);
				end
			end
			"K": begin
				if (p0 == 0) blank_span(crow, ccol, NCOLS);
				else if (p0 == 1) blank_span(crow, 0, ccol + 1);
				else blank_span(crow, 0, NCOLS);
			end
			"m": apply_rendition();
			"r": begin
				t = (pcnt > 0 ? p0 : 1) - 1;
				b = (pcnt > 1 ? p1 : NROWS) - 1;
				if (t < 0) t = 0;
				if (b > NROWS - 1) b = NROWS - 1;
				if (t > b) begin
					t = 0;
					b = NROWS - 1;
				end
				rtop = t;
				rbot = b;
				crow = 0;
				ccol = 0;
			end
			"s": begin
				srow = crow;
				scol = ccol;
			end
			"u": move_to(srow, scol);
			"M", "S": scroll_rows_up(rtop, rbot, n);
			"T": scroll_rows_down(rtop, rbot, n);
			"L": begin
				if (crow <= rbot) scroll_rows_down(crow, rbot, n);
				else blank_span(crow, 0, NCOLS);
			end
			default: ;
		endcase
	endfunction

	// parser of the shadow terminal, one byte
	function automatic void absorb_byte(logic [7:0] b);
		int c, k, v;
		case (pstate)
			PS_GROUND: begin
				if (b == ESC_CODE) pstate = PS_ESC;
				else if (b == SO_CODE) cset[CS_G1_ACTIVE] = 1'b1;
				else if (b == SI_CODE) cset[CS_G1_ACTIVE] = 1'b0;
				else if (b == BS_CODE) begin
					if (ccol > 0) ccol--;
				end else if (b == HT_CODE) begin
					c = (ccol + 8) & ~7;
					ccol = c > NCOLS - 1 ? NCOLS - 1 : c;
				end else if (b == LF_CODE) begin
					ccol = 0;
					step_down();
				end else if (b == CR_CODE) ccol = 0;
				else if (b >= SPACE_CODE) begin
					if (ccol >= NCOLS) begin
						ccol = 0;
						step_down();
					end
					sh_char[crow*NCOLS+ccol] = line_glyph(b);
					sh_attr[crow*NCOLS+ccol] = cattr;
					ccol++;
				end
			end
			PS_ESC: begin
				pstate = PS_GROUND;
				if (b == "[") begin
					pstate = PS_CSI;
					pcnt = 0;
					prm[0] = 0;
					fdigit = 1'b0;
					fpriv = 1'b0;
				end else if (b == "(" || b == ")") begin
					cset[CS_TARGET_G1] = (b == ")");
					pstate = PS_DESIG;
				end else if (b == "D") step_down();
				else if (b == "E") begin
					ccol = 0;
					step_down();
				end else if (b == "M") step_up();
				else if (b == "7") begin
					srow = crow;
					scol = ccol;
				end else if (b == "8") move_to(srow, scol);
			end
			PS_CSI: begin
				if (b >= "0" && b <= "9") begin
					if (pcnt == 0) pcnt = 1;
					k = pcnt - 1;
					if (k >= NPARAMS) k = NPARAMS - 1;
					v = prm[k] * 10 + (b - "0");
					prm[k] = v > PARAM_MAX ? PARAM_MAX : v;
					fdigit = 1'b1;
				end else if (b == ";") begin
					if (pcnt == 0) pcnt = 1;
					if (pcnt < NPARAMS) begin
						prm[pcnt] = 0;
						pcnt++;
					end
					fdigit = 1'b0;
				end else if (b == "?" && pcnt == 0 && !fdigit) begin
					fpriv = 1'b1;
				end else if (b == ">" || b == "=") begin
				end else if (b >= 8'h40 && b <= 8'h7E) begin
					run_final(b);
					pstate = PS_GROUND;
					fpriv = 1'b0;
				end else begin
					pstate = PS_GROUND;
					fpriv = 1'b0;
				end
			end
			default: begin
				if (cset[CS_TARGET_G1]) begin
					cset[CS_G1_GFX] = (b == "0");
					cset[CS_G1_ACTIVE] = (b == "0");
				end else begin
					cset[CS_G0_GFX] = (b == "0");
				end
				pstate = PS_GROUND;
			end
		endcase
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < NROWS*NCOLS; i++) begin
			sh_char[i] = SPACE_CODE;
			sh_attr[i] = RESET_ATTR;
		end
		crow = 0; ccol = 0; srow = 0; scol = 0;
		cattr = RESET_ATTR;
		rtop = 0; rbot = NROWS - 1;
		pstate = PS_GROUND;
		for (int i = 0; i < NPARAMS; i++) prm[i] = 0;
		pcnt = 0;
		fdigit = 1'b0;
		fpriv = 1'b0;
		cset = '0;
	endfunction

	// one input transaction, with the expected cell queued at acceptance
	task automatic send_item(logic cmd, logic [7:0] b, logic [4:0] row, logic [6:0] col);
		cell_result_t exp_cell;
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'd0, col, row, b};
		do @(posedge clk); while (!s_tready);
		exp_cell.ch = 8'd0;
		exp_cell.at = 8'd0;
		if (cmd == CMD_READ) begin
			if (row < NROWS && col < NCOLS) begin
				exp_cell.ch = sh_char[row*NCOLS+col];
				exp_cell.at = sh_attr[row*NCOLS+col];
			end
		end else begin
			absorb_byte(b);
		end
		exp_cell.row = crow[4:0];
		exp_cell.col = ccol[6:0];
		pending_cells.push_back(exp_cell);
	endtask

	task automatic feed(logic [7:0] b);
		send_item(CMD_FEED, b, 5'($urandom), 7'($urandom));
	endtask

	task automatic feed_str(string s);
		for (int i = 0; i < s.len(); i++) feed(s[i]);
	endtask

	task automatic read_cell(int row, int col);
		send_item(CMD_READ, 8'($urandom), row[4:0], col[6:0]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// result side: random stall and field by field check
	always @(posedge clk) begin
		cell_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_cells.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, 0);
			end else begin
				want = pending_cells.pop_front();
				if (m_tdata[7:0] !== want.ch) report_mismatch("cell_char", m_tdata[7:0], want.ch);
				if (m_tdata[15:8] !== want.at)
					report_mismatch("cell_attr", m_tdata[15:8], want.at);
				if (m_tdata[20:16] !== want.row)
					report_mismatch("cursor_row", m_tdata[20:16], want.row);
				if (m_tdata[27:21] !== want.col)
					report_mismatch("cursor_col", m_tdata[27:21], want.col);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// directed: controls, escapes, charsets, read limits
	task automatic test_directed();
		read_cell(0, 0);
		read_cell(31, 127);
		feed(8'hFF);
		feed(8'h00);
		feed(ESC_CODE); feed_str("(0q");
		feed(SO_CODE);
		feed(ESC_CODE); feed_str(")0x");
		feed(SI_CODE);
		feed(BS_CODE);
		feed(HT_CODE);
		feed(LF_CODE);
		feed(CR_CODE);
		read_cell(0, 0);
		read_cell(0, 1);
		read_cell(24, 79);
	endtask

	// random parameter list in decimal, with empty and saturating entries
	task automatic feed_params(int count);
		int v;
		string s;
		for (int i = 0; i < count; i++) begin
			if (i > 0) feed(";");
			case ($urandom_range(9))
				0: v = -1;
				1: v = $urandom_range(70000, 999999);
				2, 3: v = $urandom_range(0, 100);
				default: v = $urandom_range(0, 30);
			endcase
			if (v >= 0) begin
				s = $sformatf("%0d", v);
				feed_str(s);
			end
		end
	endtask

	// one random well-formed or broken sequence
	task automatic random_sequence();
		string finals = "HfABCDJKmrsuMSTL";
		string escs = "DEM78()[";
		logic [7:0] e;
		case ($urandom_range(19))
			0, 1, 2, 3: feed(8'($urandom_range(8'h20, 8'hFF)));
			4: feed_str("qxlkmjtuvwn");
			5: begin
				e = escs[$urandom_range(escs.len() - 1)];
				feed(ESC_CODE);
				feed(e);
				if (e == "(" || e == ")") feed($urandom_range(1) ? "0" : "B");
				else if (e == "[") feed(8'($urandom));
			end
			6: begin
				case ($urandom_range(5))
					0: feed(BS_CODE);
					1: feed(HT_CODE);
					2: feed(LF_CODE);
					3: feed(CR_CODE);
					4: feed(SO_CODE);
					default: feed(SI_CODE);
				endcase
			end
			7, 8: read_cell($urandom_range(31), $urandom_range(127));
			9, 10: read_cell($urandom_range(NROWS - 1), $urandom_range(NCOLS - 1));
			11: feed(8'($urandom));
			12: begin
				// pending wrap then printing
				feed(ESC_CODE); feed("[");
				feed_str($sformatf("%0d;80H", $urandom_range(1, NROWS)));
				feed(8'($urandom_range(8'h21, 8'h7E)));
				feed(8'($urandom_range(8'h21, 8'h7E)));
			end
			default: begin
				feed(ESC_CODE);
				feed("[");
				if ($urandom_range(9) == 0) feed("?");
				if ($urandom_range(14) == 0) feed($urandom_range(1) ? ">" : "=");
				feed_params($urandom_range(9) == 0 ? $urandom_range(9, 11) : $urandom_range(0, 3));
				case ($urandom_range(9))
					0: feed(8'($urandom_range(8'h40, 8'h7E)));
					1: feed($urandom_range(1) ? 8'h1F : 8'h7F);
					default: feed(finals[$urandom_range(finals.len() - 1)]);
				endcase
			end
		endcase
	endtask

	task automatic test_random_phase(int items, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < items; i++) random_sequence();
		wait_drained();
	endtask

	initial begin
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 18;
		recv_idle_pct = 53;
		test_directed();
		wait_drained();
		test_random_phase(18, 18, 53);
		test_random_phase(18, 53, 18);
		test_random_phase(18, 0, 0);
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (error_count == 0 && pending_cells.size() == 0) begin
			$display("** ansi_terminal_cell_grid_core: PASSED **");
		end else begin
			$display("** ansi_terminal_cell_grid_core: FAILED **");
		end
		$finish;
	end

	// hang guard
	initial begin
		#60000000;
		$display("** ansi_terminal_cell_grid_core: FAILED **");
		$finish;
	end

endmodule
